### hw/rtl/nsc_pkg.sv
// nsc_pkg: shared types, character codes and hex helpers for the sentence checker
// used by nsc_line_state and nmea_sentence_checker; no dependencies
`default_nettype none

package nsc_pkg;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] MinLine  = 8'd9;
  localparam logic [7:0] LenMax   = 8'd255;
  localparam logic [4:0] CommaMax = 5'd30;

  localparam int AddrChars = 5;
  localparam int AddrBytes = 5;
  localparam int AddrW     = 8 * AddrBytes;
  localparam int InDataW   = 8;
  localparam int OutDataW  = 72;

  typedef enum logic [2:0] {
    ErrOk       = 3'd0,
    ErrShort    = 3'd1,
    ErrNoDollar = 3'd2,
    ErrNoStar   = 3'd3,
    ErrBadHex   = 3'd4,
    ErrMismatch = 3'd5
  } err_code_e;

  typedef struct packed {
    logic [7:0]       len;
    logic             dollar;
    logic [7:0]       sum;
    logic [7:0]       recent0;
    logic [7:0]       recent1;
    logic [7:0]       recent2;
    logic [4:0]       commas;
    logic [7:0]       comma_pos;
    logic [AddrW-1:0] addr;
  } line_state_t;

  typedef struct packed {
    logic [4:0]       field_count;
    logic [7:0]       address_len;
    logic [AddrW-1:0] address_word;
    logic [7:0]       computed_sum;
    logic [2:0]       error_code;
    logic             line_ok;
  } result_t;

  localparam int ResultW = $bits(result_t);

  function automatic logic is_hex(logic [7:0] c);
    logic digit;
    logic upper;
    logic lower;
    digit = (c >= 8'h30) && (c <= 8'h39);
    upper = (c >= 8'h41) && (c <= 8'h46);
    lower = (c >= 8'h61) && (c <= 8'h66);
    return digit || upper || lower;
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [3:0] v;
    if (c <= 8'h39) begin
      v = c[3:0];
    end else begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/nmea_sentence_checker.sv
// nmea_sentence_checker: byte-serial NMEA 0183 sentence checker, one verdict per line
// depends on nsc_pkg and nsc_line_state
//
//  channel  dir  beat                 tdata fields (low bit first)
//  s_axis   in   one received byte    rx_byte[7:0]
//  m_axis   out  one line verdict     line_ok, error_code, computed_sum, address_word,
//                                     address_len, field_count, zero fill to 72 bits
//
// a byte is taken every cycle unless a line end is stalled; it is held in the input
// register, then line state update and verdict run in one pass into the result register
// the verdict of a CR or LF beat passes the input register, then the result register
// reset clears the line state and both valid flags; no clearing pass
// a stalled m_axis holds back only line-ending bytes while a verdict is still pending
`default_nettype none

module nmea_sentence_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [nsc_pkg::InDataW-1:0]   s_axis_tdata,   // rx_byte[7:0]
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [nsc_pkg::OutDataW-1:0]  m_axis_tdata    // line_ok[0], error_code[3:1],
                                                             // computed_sum[11:4],
                                                             // address_word[51:12],
                                                             // address_len[59:52],
                                                             // field_count[64:60]
);
  import nsc_pkg::*;

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_byte_q;
  logic        out_vld_q, out_vld_d;
  result_t     out_data_q, out_data_d;

  line_state_t line;
  logic        eol;
  logic        has_result;
  logic        advance;
  logic        load_out;
  err_code_e   code;
  logic [7:0]  checksum;
  logic        hex_ok;

  assign eol        = (in_byte_q == ChLf) || (in_byte_q == ChCr);
  assign has_result = eol && (line.len != 8'd0);
  assign advance    = in_vld_q && (!has_result || !out_vld_q || m_axis_tready);
  assign load_out   = advance && has_result;

  assign s_axis_tready = !in_vld_q || advance;

  nsc_line_state u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .line_o (line)
  );

  assign hex_ok   = is_hex(line.recent1) && is_hex(line.recent2);
  assign checksum = {hex_nibble(line.recent1), hex_nibble(line.recent2)};

  always_comb begin
    priority if (line.len < MinLine) begin
      code = ErrShort;
    end else if (!line.dollar) begin
      code = ErrNoDollar;
    end else if (line.recent0 != ChStar) begin
      code = ErrNoStar;
    end else if (!hex_ok) begin
      code = ErrBadHex;
    end else if (checksum != line.sum) begin
      code = ErrMismatch;
    end else begin
      code = ErrOk;
    end
  end

  always_comb begin
    out_data_d            = '0;
    out_data_d.line_ok    = (code == ErrOk);
    out_data_d.error_code = code;
    if ((code == ErrShort) || (code == ErrNoDollar) || (code == ErrNoStar)) begin
      out_data_d.field_count = 5'd1;
    end else begin
      out_data_d.computed_sum = line.sum;
      out_data_d.address_word = line.addr;
      out_data_d.address_len  = (line.comma_pos != 8'd0) ? line.comma_pos - 8'd1
                                                         : line.len - 8'd4;
      out_data_d.field_count  = line.commas + 5'd1;
    end
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (advance) begin
      in_vld_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end
    out_vld_d = out_vld_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (load_out) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutDataW - ResultW)'(0), out_data_q};

  a_ok_matches_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_data_q.line_ok == (out_data_q.error_code == ErrOk)))
    else $error("line_ok disagrees with error_code");

  a_early_fail_blank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && ((out_data_q.error_code == ErrShort) ||
                   (out_data_q.error_code == ErrNoDollar) ||
                   (out_data_q.error_code == ErrNoStar)))
    |-> (out_data_q.field_count == 5'd1 && out_data_q.computed_sum == 8'd0 &&
         out_data_q.address_len == 8'd0))
    else $error("early failure carries line data");

  a_eol_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && eol) |=> (line.len == 8'd0))
    else $error("line state not cleared after line end");

  a_held_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_byte_q)))
    else $error("pending byte lost while stalled");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !load_out)
    else $error("verdict overwritten before it was taken");

endmodule

`default_nettype wire

### hw/rtl/nsc_line_state.sv
// nsc_line_state: per-line state of the checker, updated once per processed byte
// depends on nsc_pkg
`default_nettype none

module nsc_line_state (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          byte_i,
  output nsc_pkg::line_state_t     line_o
);
  import nsc_pkg::*;

  line_state_t line_q, line_d;
  logic        eol;
  logic [7:0]  pos;
  logic [7:0]  c;
  logic        absorb;

  assign eol = (byte_i == ChLf) || (byte_i == ChCr);
  assign pos = line_q.len - 8'd3;
  assign c   = line_q.recent0;
  assign absorb = (line_q.len >= 8'd3) && (pos != 8'd0);

  always_comb begin
    line_d = line_q;
    if (eol) begin
      line_d = '0;
    end else begin
      if (line_q.len == 8'd0) begin
        line_d.dollar = (byte_i == ChDollar);
      end
      if (absorb) begin
        line_d.sum = line_q.sum ^ c;
        if (c == ChComma) begin
          if (line_q.commas < CommaMax) begin
            line_d.commas = line_q.commas + 5'd1;
          end
          if (line_q.comma_pos == 8'd0) begin
            line_d.comma_pos = pos;
          end
        end else if (line_q.comma_pos == 8'd0) begin
          for (int k = 0; k < AddrBytes; k++) begin
            if ((k < AddrChars) && (pos == 8'(AddrChars - k))) begin
              line_d.addr[8*k +: 8] = c;
            end
          end
        end
      end
      line_d.recent0 = line_q.recent1;
      line_d.recent1 = line_q.recent2;
      line_d.recent2 = byte_i;
      if (line_q.len != LenMax) begin
        line_d.len = line_q.len + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
    end else if (step_i) begin
      line_q <= line_d;
    end
  end

  assign line_o = line_q;

endmodule

`default_nettype wire

### verif/nmea_sentence_checker_tb.sv
// nmea_sentence_checker_tb: self-checking bench for the byte-serial NMEA sentence checker
// sends directed and random lines on s_axis, predicts each verdict and scores m_axis beats
// depends on nsc_pkg and nmea_sentence_checker

module nmea_sentence_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsc_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int RandomBytes = 850;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 10;

  localparam int TermLf   = 0;
  localparam int TermCr   = 1;
  localparam int TermCrLf = 2;

  localparam int HexUpper  = 0;
  localparam int HexLower  = 1;
  localparam int HexRandom = 2;

  typedef enum int {
    FlawNone,
    FlawSum,
    FlawHex,
    FlawNoStar,
    FlawNoDollar,
    FlawShort
  } flaw_e;

  class verdict_scoreboard;
    logic [7:0]       len_q;
    logic             dollar_q;
    logic [7:0]       body_xor_q;
    logic [7:0]       tail_q [3];
    logic [4:0]       commas_q;
    logic [7:0]       comma_pos_q;
    logic [AddrW-1:0] addr_q;
    result_t          pending_verdicts [$];
    int               errors;
    int               bytes_taken;
    int               verdicts_seen;
    int               code_hits [6];

    function new();
      errors        = 0;
      bytes_taken   = 0;
      verdicts_seen = 0;
      foreach (code_hits[i]) code_hits[i] = 0;
      clear_line();
    endfunction

    static function int hex_val(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
    endfunction

    function void clear_line();
      len_q       = '0;
      dollar_q    = 1'b0;
      body_xor_q  = '0;
      foreach (tail_q[i]) tail_q[i] = '0;
      commas_q    = '0;
      comma_pos_q = '0;
      addr_q      = '0;
    endfunction

    // a byte joins the body only once it drops out of the three-byte tail
    function void fold_byte(logic [7:0] c, logic [7:0] pos);
      if (pos == 0) return;
      body_xor_q ^= c;
      if (c == ChComma) begin
        if (commas_q < CommaMax) commas_q++;
        if (comma_pos_q == 0) comma_pos_q = pos;
      end else if (comma_pos_q == 0 && pos <= AddrChars) begin
        addr_q |= AddrW'(c) << (8 * (AddrChars - int'(pos)));
      end
    endfunction

    function result_t predict_verdict();
      result_t   v;
      err_code_e code;
      int        hi;
      int        lo;
      hi = hex_val(tail_q[1]);
      lo = hex_val(tail_q[2]);
      if (len_q < MinLine) code = ErrShort;
      else if (!dollar_q) code = ErrNoDollar;
      else if (tail_q[0] != ChStar) code = ErrNoStar;
      else if (hi < 0 || lo < 0) code = ErrBadHex;
      else if (hi * 16 + lo != int'(body_xor_q)) code = ErrMismatch;
      else code = ErrOk;
      v             = '0;
      v.line_ok     = (code == ErrOk);
      v.error_code  = code;
      v.field_count = 5'd1;
      if (code == ErrOk || code == ErrBadHex || code == ErrMismatch) begin
        v.computed_sum = body_xor_q;
        v.address_word = addr_q;
        v.address_len  = (comma_pos_q != 0) ? comma_pos_q - 8'd1 : len_q - 8'd4;
        v.field_count  = commas_q + 5'd1;
      end
      return v;
    endfunction

    function void note_byte(logic [7:0] b);
      bytes_taken++;
      if (b == ChLf || b == ChCr) begin
        if (len_q != 0) begin
          pending_verdicts.push_back(predict_verdict());
          clear_line();
        end
      end else begin
        if (len_q == 0) dollar_q = (b == ChDollar);
        if (len_q >= 3) fold_byte(tail_q[0], len_q - 8'd3);
        tail_q[0] = tail_q[1];
        tail_q[1] = tail_q[2];
        tail_q[2] = b;
        if (len_q != LenMax) len_q++;
      end
    endfunction

    function void match_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(logic [OutDataW-1:0] beat);
      result_t got;
      result_t want;
      got = beat[ResultW-1:0];
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict beat %h with no line pending", $time, beat);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      code_hits[int'(want.error_code)]++;
      match_field("line_ok", want.line_ok, got.line_ok);
      match_field("error_code", want.error_code, got.error_code);
      match_field("computed_sum", want.computed_sum, got.computed_sum);
      match_field("address_word", want.address_word, got.address_word);
      match_field("address_len", want.address_len, got.address_len);
      match_field("field_count", want.field_count, got.field_count);
      match_field("zero fill", '0, beat[OutDataW-1:ResultW]);
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  verdict_scoreboard board;
  logic [7:0]        line_bytes [$];
  bit                tx_calm   = 1'b0;
  bit                hold_req  = 1'b0;
  int                bytes_sent = 0;
  int                holds_done = 0;
  int                idle_cycles = 0;

  nmea_sentence_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [7:0] hex_char(logic [3:0] nib, bit lower);
    if (nib < 4'd10) return 8'h30 + nib;
    return (lower ? 8'h61 : 8'h41) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ChLf || c == ChCr || c == ChStar);
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic quiet_tx();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_line();
    tx_calm = ($urandom_range(0, 4) == 0);
    foreach (line_bytes[i]) push_byte(line_bytes[i]);
  endtask

  task automatic end_line(input int term);
    case (term)
      TermLf: begin
        line_bytes.push_back(ChLf);
      end
      TermCr: begin
        line_bytes.push_back(ChCr);
      end
      default: begin
        line_bytes.push_back(ChCr);
        line_bytes.push_back(ChLf);
      end
    endcase
  endtask

  task automatic run_sentence(input int addr_n, input int n_commas, input int fld_min,
                              input int fld_max, input flaw_e flaw, input int term,
                              input int hex_case);
    logic [7:0] sum;
    logic [7:0] c;
    bit         lower;
    int         keep;
    line_bytes = {};
    line_bytes.push_back(ChDollar);
    sum = '0;
    for (int i = 0; i < addr_n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        c = body_char();
        if (c == ChComma) c = 8'h5A;
      end else begin
        c = 8'h41 + 8'($urandom_range(0, 25));
      end
      line_bytes.push_back(c);
      sum ^= c;
    end
    for (int i = 0; i < n_commas; i++) begin
      line_bytes.push_back(ChComma);
      sum ^= ChComma;
      repeat ($urandom_range(fld_min, fld_max)) begin
        c = body_char();
        line_bytes.push_back(c);
        sum ^= c;
      end
    end
    lower = (hex_case == HexRandom) ? bit'($urandom_range(0, 1)) : (hex_case == HexLower);
    if (flaw == FlawSum) sum ^= 8'($urandom_range(1, 255));
    line_bytes.push_back((flaw == FlawNoStar) ? body_char() : ChStar);
    line_bytes.push_back(hex_char(sum[7:4], lower));
    line_bytes.push_back(hex_char(sum[3:0], lower));
    if (flaw == FlawHex) begin
      do c = body_char();
      while (verdict_scoreboard::hex_val(c) >= 0);
      line_bytes[line_bytes.size() - 1 - $urandom_range(0, 1)] = c;
    end
    if (flaw == FlawNoDollar) begin
      do c = body_char();
      while (c == ChDollar);
      line_bytes[0] = c;
    end
    if (flaw == FlawShort) begin
      keep = $urandom_range(1, 8);
      while (line_bytes.size() > keep) void'(line_bytes.pop_back());
    end
    end_line(term);
    send_line();
  endtask

  // beat monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.note_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) board.check_verdict(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no beat for %0d cycles, %0d verdicts outstanding", $time,
                 idle_cycles, board.pending());
        $display("nmea_sentence_checker_tb: errors");
        $finish;
      end
    end
  end

  // verdict receiver
  initial begin
    int wait_n;
    int calm_left;
    calm_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (calm_left > 0) begin
        wait_n = 0;
        calm_left--;
      end else begin
        wait_n = $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0) calm_left = 25;
      end
      if (hold_req) begin
        wait_n   = HoldCycles;
        hold_req = 1'b0;
        holds_done++;
      end
      if (wait_n > 0) begin
        m_axis_tready = 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  initial begin
    int    grade;
    int    commas;
    int    lines_done;
    int    start_bytes;
    flaw_e flaw;
    board = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed lines
    run_sentence(5, 3, 1, 4, FlawNone, TermCrLf, HexUpper);
    run_sentence(5, 0, 0, 0, FlawNone, TermLf, HexLower);
    run_sentence(0, 6, 0, 0, FlawNone, TermCr, HexUpper);
    run_sentence(8, 2, 0, 3, FlawNone, TermLf, HexLower);
    run_sentence(3, 2, 0, 3, FlawShort, TermLf, HexUpper);
    run_sentence(5, 2, 0, 3, FlawNoDollar, TermCr, HexUpper);
    run_sentence(5, 2, 0, 3, FlawNoStar, TermLf, HexUpper);
    run_sentence(5, 2, 0, 3, FlawHex, TermLf, HexLower);
    run_sentence(5, 2, 0, 3, FlawSum, TermCrLf, HexUpper);
    run_sentence(2, 40, 0, 1, FlawNone, TermLf, HexUpper);
    run_sentence(270, 0, 0, 0, FlawNone, TermLf, HexLower);
    line_bytes = {8'h00, 8'hFF};
    end_line(TermLf);
    send_line();
    line_bytes = {ChDollar};
    end_line(TermCr);
    send_line();
    line_bytes = {};
    end_line(TermCrLf);
    send_line();

    // random lines, mostly well formed
    lines_done  = 0;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RandomBytes) begin
      if (lines_done == 8) hold_req = 1'b1;
      if (lines_done == 16) begin
        quiet_tx();
        while (board.pending() != 0) @(posedge clk_i);
      end
      grade = $urandom_range(0, 99);
      if (grade < 12) begin
        line_bytes = {};
        repeat ($urandom_range(0, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end_line(TermLf);
        send_line();
      end else if (grade < 14) begin
        run_sentence($urandom_range(200, 300), $urandom_range(0, 1), 0, 2, FlawNone,
                     $urandom_range(0, 2), HexRandom);
      end else begin
        grade = $urandom_range(0, 99);
        if (grade < 70) flaw = FlawNone;
        else if (grade < 80) flaw = FlawSum;
        else if (grade < 88) flaw = FlawHex;
        else if (grade < 92) flaw = FlawNoStar;
        else if (grade < 96) flaw = FlawNoDollar;
        else flaw = FlawShort;
        commas = ($urandom_range(0, 29) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
        run_sentence($urandom_range(0, 7), commas, 0, 6, flaw, $urandom_range(0, 2),
                     HexRandom);
      end
      lines_done++;
    end

    quiet_tx();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d bytes, %0d verdicts, %0d long output stalls", board.bytes_taken,
             board.verdicts_seen, holds_done);
    $display("verdicts by code: ok %0d short %0d no dollar %0d no star %0d bad hex %0d mismatch %0d",
             board.code_hits[ErrOk], board.code_hits[ErrShort], board.code_hits[ErrNoDollar],
             board.code_hits[ErrNoStar], board.code_hits[ErrBadHex],
             board.code_hits[ErrMismatch]);
    if (board.errors == 0) begin
      $display("nmea_sentence_checker_tb: clean");
    end else begin
      $display("nmea_sentence_checker_tb: errors");
    end
    $finish;
  end

endmodule
